// ===== rtl/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gcd_pkg: shared constants and arctangent table for great_circle_distance
// Angle formats, CORDIC depth, unit conversion constants and the atan(2^-i)
// table in degrees Q32, built at elaboration from pi in Q60.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int STAGES      = 32;
  localparam int DEG_FULL    = 23592960;
  localparam int DEG_HALF    = 11796480;
  localparam int DEG_QUARTER = 5898240;
  localparam int INV_GAIN    = 652032874;
  localparam int ONE_Q30     = 1073741824;

  localparam logic [39:0] THETA_MAX = 40'd773094113280;

  localparam logic [16:0] MILES_NUM = 17'd69169;
  localparam logic [57:0] MILES_RND = 58'd8388608000;
  localparam logic [29:0] MILES_REC = 30'd549755814;
  localparam logic [20:0] KM_NUM    = 21'd1113171;
  localparam logic [61:0] KM_RND    = 62'd83886080000;
  localparam logic [32:0] KM_REC    = 33'd7036874418;

  typedef logic [37:0] atan_tbl_t [STAGES];

  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atan_recip_q60(logic [63:0] n);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] n2;
    logic [63:0] k;
    logic [63:0] t;
    logic        sub_f;
    logic        done;
    term  = udiv64(64'd1 << 60, n);
    sum   = term;
    n2    = n * n;
    k     = 64'd1;
    sub_f = 1'b1;
    done  = 1'b0;
    for (int j = 0; j < 64; j++) begin
      if (!done) begin
        term = udiv64(term, n2);
        if (term == 64'd0) begin
          done = 1'b1;
        end else begin
          t     = udiv64(term, 64'd2 * k + 64'd1);
          sum   = sub_f ? sum - t : sum + t;
          sub_f = !sub_f;
          k     = k + 64'd1;
        end
      end
    end
    return sum;
  endfunction

  function automatic atan_tbl_t build_atan_tbl();
    atan_tbl_t   tbl;
    logic [63:0] pi_q;
    logic [63:0] r;
    logic [63:0] f;
    pi_q = 64'd16 * atan_recip_q60(64'd5) - 64'd4 * atan_recip_q60(64'd239);
    for (int i = 0; i < STAGES; i++) begin
      r = (i == 0) ? (pi_q >> 2) : atan_recip_q60(64'd1 << i);
      f = 64'd0;
      for (int b = 0; b < 40; b++) begin
        r = r << 1;
        f = f << 1;
        if (r >= pi_q) begin
          r = r - pi_q;
          f = f | 64'd1;
        end
      end
      tbl[i] = 38'((f * 64'd180 + 64'd128) >> 8);
    end
    return tbl;
  endfunction

  localparam atan_tbl_t ATAN_TBL = build_atan_tbl();

endpackage

// ===== rtl/gcd_sincos.sv =====
// ----------------------------------------------------------------------------
// gcd_sincos: pipelined sine and cosine
// Reduces an angle in degrees * 65536 to one half turn around zero, folds it
// into +-90 degrees and rotates a 32-stage CORDIC, one stage per register.
// ----------------------------------------------------------------------------
module gcd_sincos (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [25:0] in_ang,
  output logic               out_valid,
  output logic signed [31:0] out_cos,
  output logic signed [31:0] out_sin
);
  import gcd_pkg::*;

  logic signed [26:0] t0, t1, t2, t3;
  logic [24:0]        m_r;
  logic               v0_r;
  logic signed [25:0] c0, c1;
  logic               flip_nxt;

  logic signed [33:0] x_r [STAGES+1];
  logic signed [33:0] y_r [STAGES+1];
  logic signed [40:0] z_r [STAGES+1];
  logic               f_r [STAGES+1];
  logic               v_r [STAGES+1];
  logic               vo_r;
  logic signed [31:0] cos_r, sin_r;

  always_comb begin
    t0 = 27'(in_ang);
    t1 = (t0 < 0) ? t0 + $signed(27'(DEG_FULL)) : t0;
    t2 = (t1 < 0) ? t1 + $signed(27'(DEG_FULL)) : t1;
    t3 = (t2 >= $signed(27'(DEG_FULL))) ? t2 - $signed(27'(DEG_FULL)) : t2;
  end

  always_comb begin
    c0 = $signed({1'b0, m_r});
    if (c0 > $signed(26'(DEG_HALF))) c0 = c0 - $signed(26'(DEG_FULL));
    flip_nxt = 1'b0;
    c1 = c0;
    if (c0 > $signed(26'(DEG_QUARTER))) begin
      c1 = c0 - $signed(26'(DEG_HALF));
      flip_nxt = 1'b1;
    end else if (c0 < -$signed(26'(DEG_QUARTER))) begin
      c1 = c0 + $signed(26'(DEG_HALF));
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= 25'(t3);
      x_r[0] <= 34'(INV_GAIN);
      y_r[0] <= '0;
      z_r[0] <= $signed({c1, 15'd0}) <<< 1;
      f_r[0] <= flip_nxt;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - $signed({3'b000, ATAN_TBL[i]});
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + $signed({3'b000, ATAN_TBL[i]});
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= f_r[STAGES] ? 32'(-x_r[STAGES]) : 32'(x_r[STAGES]);
      sin_r <= f_r[STAGES] ? 32'(-y_r[STAGES]) : 32'(y_r[STAGES]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v_r[0] <= 1'b0;
      vo_r   <= 1'b0;
    end else if (en) begin
      v0_r   <= in_valid;
      v_r[0] <= v0_r;
      vo_r   <= v_r[STAGES];
    end
  end

  assign out_valid = vo_r;
  assign out_cos   = cos_r;
  assign out_sin   = sin_r;

endmodule

// ===== rtl/gcd_isqrt.sv =====
// ----------------------------------------------------------------------------
// gcd_isqrt: pipelined integer square root
// Floor square root of a 61-bit value, one result bit per register stage,
// with a side tag carried alongside.
// ----------------------------------------------------------------------------
module gcd_isqrt #(
  parameter int TAG_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [60:0]      in_rad,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [30:0]      out_root,
  output logic [TAG_W-1:0] out_tag
);
  import gcd_pkg::*;

  localparam int STEPS = 31;

  logic [61:0]      v_r   [STEPS+1];
  logic [61:0]      res_r [STEPS+1];
  logic [TAG_W-1:0] tag_r [STEPS+1];
  logic             vl_r  [STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]   <= 62'(in_rad);
      res_r[0] <= '0;
      tag_r[0] <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r[0] <= 1'b0;
    end else if (en) begin
      vl_r[0] <= in_valid;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
    logic [61:0] sum;
    assign sum = res_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k+1] <= tag_r[k];
        if (v_r[k] >= sum) begin
          v_r[k+1]   <= v_r[k] - sum;
          res_r[k+1] <= (res_r[k] >> 1) + BIT;
        end else begin
          v_r[k+1]   <= v_r[k];
          res_r[k+1] <= res_r[k] >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[k+1] <= 1'b0;
      end else if (en) begin
        vl_r[k+1] <= vl_r[k];
      end
    end
  end

  assign out_valid = vl_r[STEPS];
  assign out_root  = res_r[STEPS][30:0];
  assign out_tag   = tag_r[STEPS];

endmodule

// ===== rtl/gcd_acos.sv =====
// ----------------------------------------------------------------------------
// gcd_acos: pipelined vectoring CORDIC arccosine
// Takes |c| and sqrt(1 - c^2) in Q30, returns the angle in degrees Q32,
// mirrored about 90 degrees for negative c and clamped to 0..180 degrees.
// ----------------------------------------------------------------------------
module gcd_acos (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [30:0] in_x,
  input  logic [30:0] in_y,
  input  logic        in_neg,
  output logic        out_valid,
  output logic [39:0] out_theta
);
  import gcd_pkg::*;

  logic signed [33:0] x_r [STAGES+1];
  logic signed [33:0] y_r [STAGES+1];
  logic signed [40:0] z_r [STAGES+1];
  logic               n_r [STAGES+1];
  logic               v_r [STAGES+1];
  logic               vo_r;
  logic [39:0]        th_r;
  logic signed [41:0] th_full;
  logic [39:0]        th_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= $signed({3'b000, in_x});
      y_r[0] <= $signed({3'b000, in_y});
      z_r[0] <= '0;
      n_r[0] <= in_neg;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i+1] <= n_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + $signed({3'b000, ATAN_TBL[i]});
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - $signed({3'b000, ATAN_TBL[i]});
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end
  end

  always_comb begin
    th_full = n_r[STAGES] ? $signed({2'b00, THETA_MAX}) - 42'(z_r[STAGES])
                          : 42'(z_r[STAGES]);
    if (th_full < 0) begin
      th_nxt = '0;
    end else if (th_full > $signed({2'b00, THETA_MAX})) begin
      th_nxt = THETA_MAX;
    end else begin
      th_nxt = th_full[39:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) th_r <= th_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
      vo_r   <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      vo_r   <= v_r[STAGES];
    end
  end

  assign out_valid = vo_r;
  assign out_theta = th_r;

endmodule

// ===== rtl/great_circle_distance.sv =====
// ----------------------------------------------------------------------------
// great_circle_distance: spherical law of cosines distance pipeline
// Central angle between two points and the distance in miles and km.
// ----------------------------------------------------------------------------
// Input channel in_*: one point pair per transaction, latitudes and
// longitudes in signed degrees * 65536. Output channel out_*: one result
// per input transaction, angle in degrees * 65536, distances * 256.
// Throughput: one transaction per cycle while out_tready does not hold the
// pipeline. The path runs through the 35-stage sine/cosine pipeline, four
// product and clamp stages, the 32-stage square root, the 34-stage
// arccosine CORDIC and three scaling stages.
// Every stage advances on one common enable; when the receiver holds
// out_tready low with a result waiting, the whole pipeline holds and
// in_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and ready at once.
// ----------------------------------------------------------------------------
module great_circle_distance (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // lat_a[23:0], lon_a[48:24], lat_b[72:49], lon_b[97:73]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata  // arc_degrees[23:0], dist_miles[45:24], dist_km[68:46]
);
  import gcd_pkg::*;

  logic               en;
  logic signed [23:0] lat_a, lat_b;
  logic signed [24:0] lon_a, lon_b;
  logic signed [25:0] dlon;

  logic               v_sc;
  logic signed [31:0] ca, sa, cb, sb, cd, sd;
  logic               v_b_unused, v_d_unused;

  logic signed [63:0] p_ab, p_ss, p_q;
  logic signed [31:0] ab_r, ss_r, cd_r, q_r, ss2_r;
  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [32:0] cs;
  logic signed [32:0] csc;
  logic               neg_r;
  logic [30:0]        mag_r;
  logic [61:0]        sq;
  logic [60:0]        rad_r;
  logic [31:0]        tag4_r;

  logic               v_sq;
  logic [30:0]        root;
  logic [31:0]        tag_sq;
  logic               v_ac;
  logic [39:0]        theta;

  logic               vf1_r, vf2_r, vo_r;
  logic [23:0]        arc1_r, arc2_r, arc_r;
  logic [57:0]        nm_r;
  logic [61:0]        nk_r;
  logic [58:0]        qm_r;
  logic [64:0]        qk_r;
  logic [21:0]        miles_r;
  logic [22:0]        km_r;

  assign en        = !vo_r || out_tready;
  assign in_tready = en;

  assign lat_a = in_tdata[23:0];
  assign lon_a = in_tdata[48:24];
  assign lat_b = in_tdata[72:49];
  assign lon_b = in_tdata[97:73];
  assign dlon  = 26'(lon_a) - 26'(lon_b);

  gcd_sincos u_sc_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .in_ang(26'(lat_a)), .out_valid(v_sc), .out_cos(ca), .out_sin(sa)
  );

  gcd_sincos u_sc_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .in_ang(26'(lat_b)), .out_valid(v_b_unused), .out_cos(cb), .out_sin(sb)
  );

  gcd_sincos u_sc_d (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .in_ang(dlon), .out_valid(v_d_unused), .out_cos(cd), .out_sin(sd)
  );

  assign p_ab = ca * cb;
  assign p_ss = sa * sb;
  assign p_q  = ab_r * cd_r;

  always_comb begin
    cs = 33'(q_r) + 33'(ss2_r);
    if (cs > $signed(33'(ONE_Q30))) begin
      csc = 33'(ONE_Q30);
    end else if (cs < -$signed(33'(ONE_Q30))) begin
      csc = -$signed(33'(ONE_Q30));
    end else begin
      csc = cs;
    end
  end

  assign sq = 62'(mag_r) * 62'(mag_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ab_r   <= 32'(p_ab >>> 30);
      ss_r   <= 32'(p_ss >>> 30);
      cd_r   <= cd;
      q_r    <= 32'(p_q >>> 30);
      ss2_r  <= ss_r;
      neg_r  <= csc[32];
      mag_r  <= csc[32] ? 31'(-csc) : 31'(csc);
      rad_r  <= 61'((62'd1 << 60) - sq);
      tag4_r <= {neg_r, mag_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_sc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  gcd_isqrt #(.TAG_W(32)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_r),
    .in_rad(rad_r), .in_tag(tag4_r),
    .out_valid(v_sq), .out_root(root), .out_tag(tag_sq)
  );

  gcd_acos u_acos (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_sq),
    .in_x(tag_sq[30:0]), .in_y(root), .in_neg(tag_sq[31]),
    .out_valid(v_ac), .out_theta(theta)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      arc1_r  <= 24'((41'(theta) + 41'd32768) >> 16);
      nm_r    <= 58'(theta) * 58'(MILES_NUM) + MILES_RND;
      nk_r    <= 62'(theta) * 62'(KM_NUM) + KM_RND;
      arc2_r  <= arc1_r;
      qm_r    <= 59'(nm_r[55:27]) * 59'(MILES_REC);
      qk_r    <= 65'(nk_r[59:28]) * 65'(KM_REC);
      arc_r   <= arc2_r;
      miles_r <= qm_r[57:36];
      km_r    <= qk_r[64:42];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf1_r <= 1'b0;
      vf2_r <= 1'b0;
      vo_r  <= 1'b0;
    end else if (en) begin
      vf1_r <= v_ac;
      vf2_r <= vf1_r;
      vo_r  <= vf2_r;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {3'b000, km_r, miles_r, arc_r};

endmodule

// ===== bench/great_circle_distance_tb.sv =====
// ----------------------------------------------------------------------------
// great_circle_distance_tb: self-checking bench for great_circle_distance
// Drives point pairs on the input stream and predicts the angle and both
// distances with a fixed-point CORDIC model of its own. Results are checked
// in order, field by field, under random idle cycles on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module great_circle_distance_tb;

  localparam int           STAGES    = 32;
  localparam longint       FULL_TURN = 23592960;
  localparam longint       HALF_TURN = 11796480;
  localparam longint       QTR_TURN  = 5898240;
  localparam longint       UNIT_Q30  = 64'sd1073741824;
  localparam longint       START_X   = 652032874;
  localparam int           LAT_MAX   = 5898240;
  localparam int           LON_MAX   = 11796480;
  localparam int           DRAIN_CYC = 130;

  typedef struct packed {
    logic [22:0] dist_km;
    logic [21:0] dist_miles;
    logic [23:0] arc_degrees;
  } distance_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;   // lat_a, lon_a, lat_b, lon_b
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;  // arc_degrees, dist_miles, dist_km

  longint    atan_deg [STAGES];
  distance_t pending_distances [$];
  int        mismatches;
  int        pairs_sent;
  int        results_seen;
  bit        steady_flow;

  great_circle_distance uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned inv_atan_q60(longint unsigned n);
    longint unsigned term;
    longint unsigned acc;
    longint unsigned k;
    bit              neg;
    term = (64'd1 << 60) / n;
    acc  = term;
    k    = 1;
    neg  = 1'b1;
    forever begin
      term = term / (n * n);
      if (term == 0) break;
      acc = neg ? acc - term / (2 * k + 1) : acc + term / (2 * k + 1);
      neg = !neg;
      k++;
    end
    return acc;
  endfunction

  task automatic fill_atan_table();
    longint unsigned pi_q60;
    longint unsigned rem;
    longint unsigned frac;
    pi_q60 = 16 * inv_atan_q60(5) - 4 * inv_atan_q60(239);
    for (int i = 0; i < STAGES; i++) begin
      rem  = (i == 0) ? (pi_q60 >> 2) : inv_atan_q60(64'd1 << i);
      frac = 0;
      for (int b = 0; b < 40; b++) begin
        rem  = rem << 1;
        frac = frac << 1;
        if (rem >= pi_q60) begin
          rem  = rem - pi_q60;
          frac = frac | 1;
        end
      end
      atan_deg[i] = longint'((frac * 180 + 128) >> 8);
    end
  endtask

  task automatic rotate_q30(input longint ang, output longint cos_v, output longint sin_v);
    longint m;
    longint x;
    longint y;
    longint z;
    longint nx;
    bit     flip;
    m    = ang % FULL_TURN;
    flip = 1'b0;
    if (m < 0) m += FULL_TURN;
    if (m > HALF_TURN) m -= FULL_TURN;
    if (m > QTR_TURN) begin
      m -= HALF_TURN;
      flip = 1'b1;
    end else if (m < -QTR_TURN) begin
      m += HALF_TURN;
      flip = 1'b1;
    end
    x = START_X;
    y = 0;
    z = m * 65536;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_deg[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_deg[i];
      end
      x = nx;
    end
    cos_v = flip ? -x : x;
    sin_v = flip ? -y : y;
  endtask

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic predict_distance(input logic [23:0] lat_a, input logic [24:0] lon_a,
                                  input logic [23:0] lat_b, input logic [24:0] lon_b,
                                  output distance_t d);
    longint          ca, sa, cb, sb, cd, sd;
    longint          csum, mag, x, y, z, nx, theta;
    longint unsigned th;
    rotate_q30(longint'(signed'(lat_a)), ca, sa);
    rotate_q30(longint'(signed'(lat_b)), cb, sb);
    rotate_q30(longint'(signed'(lon_a)) - longint'(signed'(lon_b)), cd, sd);
    csum = ((((ca * cb) >>> 30) * cd) >>> 30) + ((sa * sb) >>> 30);
    if (csum > UNIT_Q30) csum = UNIT_Q30;
    if (csum < -UNIT_Q30) csum = -UNIT_Q30;
    mag = csum < 0 ? -csum : csum;
    x   = mag;
    y   = longint'(root64((64'd1 << 60) - longint'(mag * mag)));
    z   = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_deg[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_deg[i];
      end
      x = nx;
    end
    theta = csum < 0 ? (64'sd180 <<< 32) - z : z;
    if (theta < 0) theta = 0;
    if (theta > (64'sd180 <<< 32)) theta = 64'sd180 <<< 32;
    th = longint'(theta);
    d.arc_degrees = 24'((th + (64'd1 << 15)) >> 16);
    d.dist_miles  = 22'((th * 69169 + (64'd1000 << 23)) / (64'd1000 << 24));
    d.dist_km     = 23'((th * 1113171 + (64'd10000 << 23)) / (64'd10000 << 24));
  endtask

  task automatic send_pair(input int lat_a, input int lon_a,
                           input int lat_b, input int lon_b);
    int        gap;
    distance_t d;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, lon_b[24:0], lat_b[23:0], lon_a[24:0], lat_a[23:0]};
    do @(posedge clk); while (!in_tready);
    predict_distance(lat_a[23:0], lon_a[24:0], lat_b[23:0], lon_b[24:0], d);
    pending_distances.push_back(d);
    pairs_sent++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
  endtask

  function automatic int rand_lat();
    return int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
  endfunction

  function automatic int rand_lon();
    return int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
  endfunction

  task automatic test_directed();
    send_pair(0, 0, 0, 0);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(0, -LON_MAX, 0, LON_MAX);
    send_pair(0, 0, 0, 1);
    send_pair(655360, 1310720, 655360, 1310720);
    send_pair(2621440, 655360, -2621440, -11141120);
    send_pair('h7fffff, 'h0ffffff, 'h800000, 'h1000000);
    send_pair('hffffff, 'h1ffffff, 'hffffff, 'h1ffffff);
    send_pair('h800000, 'h1000000, 'h7fffff, 'h0ffffff);
    send_pair('h555555, 'h0aaaaaa, 'haaaaaa, 'h1555555);
    send_pair(LAT_MAX - 1, 0, -LAT_MAX + 1, LON_MAX);
    send_pair(3211264, -4718592, 2293760, 9437184);
    send_pair(-1, 1, 1, -1);
    send_pair(0, 5898240, 0, -5898240);
    send_pair(0, 5898240, 0, -5898241);
  endtask

  task automatic test_random_points(input int count);
    for (int n = 0; n < count; n++) begin
      send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
    end
  endtask

  task automatic test_near_antipodal(input int count);
    int lat;
    int lon;
    int lon_opp;
    for (int n = 0; n < count; n++) begin
      lat     = rand_lat();
      lon     = rand_lon();
      lon_opp = lon > 0 ? lon - LON_MAX : lon + LON_MAX;
      if (n % 2 == 0) begin
        send_pair(lat, lon, -lat + $urandom_range(0, 64) - 32, lon_opp + $urandom_range(0, 64) - 32);
      end else begin
        send_pair(lat, lon, lat + $urandom_range(0, 64) - 32, lon + $urandom_range(0, 64) - 32);
      end
    end
  endtask

  task automatic test_raw_patterns(input int count);
    for (int n = 0; n < count; n++) begin
      send_pair($urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_back_to_back(input int count);
    steady_flow = 1'b1;
    test_random_points(count);
    steady_flow = 1'b0;
  endtask

  always @(posedge clk) begin
    distance_t got;
    distance_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = distance_t'(out_tdata[68:0]);
      results_seen++;
      if (pending_distances.size() == 0) begin
        $error("unexpected result transaction %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_distances.pop_front();
        if (got.arc_degrees !== want.arc_degrees) begin
          $error("arc_degrees expected %0d actual %0d", want.arc_degrees, got.arc_degrees);
          mismatches++;
        end
        if (got.dist_miles !== want.dist_miles) begin
          $error("dist_miles expected %0d actual %0d", want.dist_miles, got.dist_miles);
          mismatches++;
        end
        if (got.dist_km !== want.dist_km) begin
          $error("dist_km expected %0d actual %0d", want.dist_km, got.dist_km);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int hold;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    rst_n       = 1'b0;
    mismatches  = 0;
    pairs_sent  = 0;
    results_seen = 0;
    steady_flow = 1'b0;
    fill_atan_table();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_points(600);
    wait_for_results();
    test_near_antipodal(300);
    test_back_to_back(300);
    test_raw_patterns(330);
    wait_for_results();
    repeat (DRAIN_CYC) @(posedge clk);
    $display("Covered %0d point pairs, %0d results: directed extremes, random points,",
             pairs_sent, results_seen);
    $display("near-coincident and near-antipodal pairs, raw bit patterns, full-rate bursts.");
    if (mismatches == 0 && pending_distances.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
